[design/dpp_pkg.sv]
// Shared constants and types for the disparity-to-point back-projection pipeline.
package dpp_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BYTE_SHIFT = 8;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Depth numerator is 1.0 in Q16.16 over a Q8.24 denominator: 2^40
  localparam int unsigned Z_ONE_BIT  = 40;

  // Quotient bits produced by each divider pipeline
  localparam int unsigned DIV_STAGES = 32;

  // Default parameter values
  localparam int unsigned COORD_BITS_DEF = 11;
  localparam int unsigned DISP_BITS_DEF  = 11;

  // Register reset values
  localparam logic        RST_BIG_ENDIAN = 1'b0;
  localparam logic [31:0] RST_OFFSET_A   = 32'd55868375;
  localparam logic [31:0] RST_SCALE_B    = 32'hFFFF_3A2D;
  localparam logic [31:0] RST_FOCAL_X    = 32'd34406400;
  localparam logic [31:0] RST_FOCAL_Y    = 32'd34406400;
  localparam logic [31:0] RST_CENTER_X   = 32'd20971520;
  localparam logic [31:0] RST_CENTER_Y   = 32'd15728640;

  // Saturation limits of the signed Q16.16 outputs
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIG_ENDIAN = 3'd0,
    REG_OFFSET_A   = 3'd1,
    REG_SCALE_B    = 3'd2,
    REG_FOCAL_X    = 3'd3,
    REG_FOCAL_Y    = 3'd4,
    REG_CENTER_X   = 3'd5,
    REG_CENTER_Y   = 3'd6
  } cfg_reg_e;

  // Side data carried alongside the depth divider
  typedef struct packed {
    logic        inv;
    logic        satz;
    logic [31:0] magx;
    logic        negx;
    logic [31:0] magy;
    logic        negy;
  } depth_sb_t;

  // Side data carried alongside the projection dividers
  typedef struct packed {
    logic        inv;
    logic [31:0] z;
    logic        satx;
    logic        negx;
    logic        saty;
    logic        negy;
  } proj_sb_t;

endpackage

[design/dpp_div_pipe.sv]
// Pipelined restoring divider: one quotient bit per register stage.
module dpp_div_pipe import dpp_pkg::*; #(
  parameter int unsigned DW = 32
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [DW-1:0]         rem_i,   // upper numerator part, below div_i
  input  logic [DIV_STAGES-1:0] lo_i,    // low numerator bits
  input  logic [DW-1:0]         div_i,
  output logic [DIV_STAGES-1:0] quo_o
);

  logic [DW-1:0]         rem_q [DIV_STAGES];
  logic [DIV_STAGES-1:0] lo_q  [DIV_STAGES];
  logic [DW-1:0]         div_q [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [DW-1:0]         rem_in;
    logic [DIV_STAGES-1:0] lo_in;
    logic [DW-1:0]         div_in;
    logic [DW:0]           part;
    logic [DW:0]           diff;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign lo_in  = lo_i;
      assign div_in = div_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign div_in = div_q[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign part = {rem_in, lo_in[DIV_STAGES-1]};
    assign ge   = part >= {1'b0, div_in};
    assign diff = part - {1'b0, div_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DW-1:0] : part[DW-1:0];
        lo_q[k]  <= {lo_in[DIV_STAGES-2:0], ge};
        div_q[k] <= div_in;
      end
    end
  end

  assign quo_o = lo_q[DIV_STAGES-1];

endmodule

[design/disparity_pixel_to_point.sv]
// Top level: depth pixel back-projection to a 3-D point, fully pipelined.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  pixel in | in_valid_i / in_ready_o | pixel_col_i pixel_row_i first/second_byte_i
//  point out| out_valid_o/ out_ready_i| point_x_o point_y_o point_z_o invalid_o
//  config   | cfg_we_i                | cfg_idx_i cfg_data_i
//
// One pixel enters per cycle while no result is held at the output; the path runs
// through two 32-step divider pipelines (depth 1/D, then the focal-length division).
// Reset clears the valid bits and loads the register defaults.
// A result held at the output freezes the whole pipeline; nothing is lost.
module disparity_pixel_to_point import dpp_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned DISP_BITS  = DISP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_W-1:0]     cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] pixel_col_i,
  input  logic [COORD_BITS-1:0] pixel_row_i,
  input  logic [BYTE_W-1:0]     first_byte_i,
  input  logic [BYTE_W-1:0]     second_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    point_x_o,
  output logic signed [31:0]    point_y_o,
  output logic [31:0]           point_z_o,
  output logic                  invalid_o
);

  localparam int unsigned BR_W  = WORD_W + DISP_BITS + 1;
  localparam int unsigned DEN_W = BR_W + 1;
  localparam int unsigned DV_W  = WORD_W + DISP_BITS;
  localparam int unsigned NUM_W = DV_W + 1;
  localparam int unsigned POS_W = COORD_BITS + FRAC_W;

  // Configuration registers
  logic        big_endian_q;
  logic [31:0] offset_a_q, scale_b_q, focal_x_q, focal_y_q, center_x_q, center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= RST_BIG_ENDIAN;
      offset_a_q   <= RST_OFFSET_A;
      scale_b_q    <= RST_SCALE_B;
      focal_x_q    <= RST_FOCAL_X;
      focal_y_q    <= RST_FOCAL_Y;
      center_x_q   <= RST_CENTER_X;
      center_y_q   <= RST_CENTER_Y;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_BIG_ENDIAN: big_endian_q <= cfg_data_i[0];
        REG_OFFSET_A:   offset_a_q   <= cfg_data_i;
        REG_SCALE_B:    scale_b_q    <= cfg_data_i;
        REG_FOCAL_X:    focal_x_q    <= cfg_data_i;
        REG_FOCAL_Y:    focal_y_q    <= cfg_data_i;
        REG_CENTER_X:   center_x_q   <= cfg_data_i;
        REG_CENTER_Y:   center_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero focal length acts as one
  logic [31:0] fx_eff, fy_eff;
  assign fx_eff = (focal_x_q == '0) ? 32'd1 : focal_x_q;
  assign fy_eff = (focal_y_q == '0) ? 32'd1 : focal_y_q;

  // Global advance: the pipeline moves unless a result is held at the output
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- Stage A: capture pixel, assemble raw disparity
  logic                  va_q;
  logic [COORD_BITS-1:0] xa_q, ya_q;
  logic [DISP_BITS-1:0]  ra_q;
  logic [BYTE_W-1:0]     hi_byte, lo_byte;
  logic [15:0]           word;

  assign hi_byte = big_endian_q ? first_byte_i  : second_byte_i;
  assign lo_byte = big_endian_q ? second_byte_i : first_byte_i;
  assign word    = {hi_byte, lo_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q <= pixel_col_i;
      ya_q <= pixel_row_i;
      ra_q <= word[DISP_BITS-1:0];
    end
  end

  // ---------------- Stage B: slope product, center offsets
  logic                   vb_q;
  logic signed [BR_W-1:0] br_q, br_d;
  logic [31:0]            posx, posy, magx_d, magy_d, magx_b_q, magy_b_q;
  logic                   negx_d, negy_d, negx_b_q, negy_b_q;

  assign br_d   = $signed(scale_b_q) * $signed({1'b0, ra_q});
  assign posx   = 32'({xa_q, {FRAC_W{1'b0}}});
  assign posy   = 32'({ya_q, {FRAC_W{1'b0}}});
  assign negx_d = posx < center_x_q;
  assign negy_d = posy < center_y_q;
  assign magx_d = negx_d ? (center_x_q - posx) : (posx - center_x_q);
  assign magy_d = negy_d ? (center_y_q - posy) : (posy - center_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      br_q     <= br_d;
      magx_b_q <= magx_d;
      magy_b_q <= magy_d;
      negx_b_q <= negx_d;
      negy_b_q <= negy_d;
    end
  end

  // ---------------- Stage C: denominator and validity
  logic                    vc_q;
  logic signed [DEN_W-1:0] den_d;
  logic [DV_W-1:0]         dc_q;
  logic                    invc_q;
  logic [31:0]             magx_c_q, magy_c_q;
  logic                    negx_c_q, negy_c_q;

  assign den_d = DEN_W'($signed(offset_a_q)) + DEN_W'(br_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dc_q     <= den_d[DV_W-1:0];
      invc_q   <= den_d[DEN_W-1] || (den_d == '0);
      magx_c_q <= magx_b_q;
      magy_c_q <= magy_b_q;
      negx_c_q <= negx_b_q;
      negy_c_q <= negy_b_q;
    end
  end

  // ---------------- Stage D: rounded numerator, overflow check
  logic             vd_q;
  logic [NUM_W-1:0] num_z;
  logic [DV_W-1:0]  nhi_ext;
  logic             satz_d;
  logic [DV_W-1:0]  remd_q, divd_q;
  logic [31:0]      lod_q;
  depth_sb_t        sbd_q;

  assign num_z   = (NUM_W'(1) << Z_ONE_BIT) + NUM_W'(dc_q >> 1);
  assign nhi_ext = DV_W'(num_z[NUM_W-1:DIV_STAGES]);
  assign satz_d  = nhi_ext >= dc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      remd_q     <= satz_d ? '0 : nhi_ext;
      lod_q      <= num_z[DIV_STAGES-1:0];
      divd_q     <= dc_q;
      sbd_q.inv  <= invc_q;
      sbd_q.satz <= satz_d;
      sbd_q.magx <= magx_c_q;
      sbd_q.negx <= negx_c_q;
      sbd_q.magy <= magy_c_q;
      sbd_q.negy <= negy_c_q;
    end
  end

  // ---------------- Depth divider and its side pipe
  logic [31:0]     zq;
  logic            v1_q  [DIV_STAGES];
  depth_sb_t       sb1_q [DIV_STAGES];

  dpp_div_pipe #(.DW(DV_W)) u_div_z (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remd_q),
    .lo_i  (lod_q),
    .div_i (divd_q),
    .quo_o (zq)
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_sb1
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q[k] <= 1'b0;
      end else if (en) begin
        v1_q[k] <= (k == 0) ? vd_q : v1_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sb1_q[k] <= (k == 0) ? sbd_q : sb1_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- Stage E: saturate depth
  logic      ve_q;
  depth_sb_t sbe_q;
  logic [31:0] ze_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en) begin
      ve_q <= v1_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ze_q  <= sb1_q[DIV_STAGES-1].satz ? '1 : zq;
      sbe_q <= sb1_q[DIV_STAGES-1];
    end
  end

  // ---------------- Stage F: depth times offset
  logic        vf_q;
  logic [63:0] prodx_q, prody_q;
  logic [31:0] zf_q;
  logic        invf_q, negx_f_q, negy_f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prodx_q  <= 64'(ze_q) * 64'(sbe_q.magx);
      prody_q  <= 64'(ze_q) * 64'(sbe_q.magy);
      zf_q     <= ze_q;
      invf_q   <= sbe_q.inv;
      negx_f_q <= sbe_q.negx;
      negy_f_q <= sbe_q.negy;
    end
  end

  // ---------------- Stage G: rounding term, overflow check
  logic        vg_q;
  logic [63:0] numx, numy;
  logic        satx_d, saty_d;
  logic [31:0] remx_q, remy_q, lox_q, loy_q, fxg_q, fyg_q;
  proj_sb_t    sbg_q;

  assign numx   = prodx_q + 64'(fx_eff >> 1);
  assign numy   = prody_q + 64'(fy_eff >> 1);
  assign satx_d = numx[63:32] >= fx_eff;
  assign saty_d = numy[63:32] >= fy_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (en) begin
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      remx_q     <= satx_d ? '0 : numx[63:32];
      remy_q     <= saty_d ? '0 : numy[63:32];
      lox_q      <= numx[31:0];
      loy_q      <= numy[31:0];
      fxg_q      <= fx_eff;
      fyg_q      <= fy_eff;
      sbg_q.inv  <= invf_q;
      sbg_q.z    <= zf_q;
      sbg_q.satx <= satx_d;
      sbg_q.negx <= negx_f_q;
      sbg_q.saty <= saty_d;
      sbg_q.negy <= negy_f_q;
    end
  end

  // ---------------- Projection dividers and side pipe
  logic [31:0] qx, qy;
  logic        v2_q  [DIV_STAGES];
  proj_sb_t    sb2_q [DIV_STAGES];

  dpp_div_pipe #(.DW(WORD_W)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remx_q),
    .lo_i  (lox_q),
    .div_i (fxg_q),
    .quo_o (qx)
  );

  dpp_div_pipe #(.DW(WORD_W)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remy_q),
    .lo_i  (loy_q),
    .div_i (fyg_q),
    .quo_o (qy)
  );

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_sb2
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v2_q[k] <= 1'b0;
      end else if (en) begin
        v2_q[k] <= (k == 0) ? vg_q : v2_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sb2_q[k] <= (k == 0) ? sbg_q : sb2_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- Stage H: sign, saturation, output register
  proj_sb_t    sbh;
  logic [31:0] px_d, py_d;
  logic        vh_q;
  logic [31:0] px_q, py_q, pz_q;
  logic        inv_q;

  assign sbh = sb2_q[DIV_STAGES-1];

  always_comb begin
    if (sbh.negx) begin
      px_d = (sbh.satx || qx > SAT_NEG) ? SAT_NEG : 32'(0) - qx;
    end else begin
      px_d = (sbh.satx || qx[31]) ? SAT_POS : qx;
    end
    if (sbh.negy) begin
      py_d = (sbh.saty || qy > SAT_NEG) ? SAT_NEG : 32'(0) - qy;
    end else begin
      py_d = (sbh.saty || qy[31]) ? SAT_POS : qy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
    end else if (en) begin
      vh_q <= v2_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q  <= sbh.inv ? '0 : px_d;
      py_q  <= sbh.inv ? '0 : py_d;
      pz_q  <= sbh.inv ? '0 : sbh.z;
      inv_q <= sbh.inv;
    end
  end

  assign out_valid_o = vh_q;
  assign point_x_o   = $signed(px_q);
  assign point_y_o   = $signed(py_q);
  assign point_z_o   = pz_q;
  assign invalid_o   = inv_q;

  // ---------------- Assertions
  // a rejected depth yields the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |-> point_x_o == 0 && point_y_o == 0 && point_z_o == 0)
    else $error("invalid point not zeroed");

  // a held result blocks new pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("pixel accepted while output stalled");

  // a stall freezes the pipeline valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vh_q) && $stable(vg_q) && $stable(vd_q) && $stable(va_q))
    else $error("pipeline moved during stall");

  // a transaction leaving stage G enters the projection side pipe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vg_q && en |=> v2_q[0])
    else $error("divider side pipe lost a transaction");

endmodule

[dv/tb.sv]
// Testbench for disparity_pixel_to_point: directed and random pixels checked against a predictor.
module tb;
  import dpp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned PIPE_LAT  = 72;
  localparam int unsigned DRAIN_CYC = PIPE_LAT + 8;
  localparam int unsigned CYC_LIMIT = 400000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        inv;
  } point_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_BIG_ENDIAN;
  logic [WORD_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [10:0]          pixel_col_i = '0;
  logic [10:0]          pixel_row_i = '0;
  logic [7:0]           first_byte_i = '0;
  logic [7:0]           second_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [31:0]   point_x_o;
  logic signed [31:0]   point_y_o;
  logic [31:0]          point_z_o;
  logic                 invalid_o;

  // Shadow copy of the register file
  logic        reg_be = RST_BIG_ENDIAN;
  logic [31:0] reg_a  = RST_OFFSET_A;
  logic [31:0] reg_b  = RST_SCALE_B;
  logic [31:0] reg_fx = RST_FOCAL_X;
  logic [31:0] reg_fy = RST_FOCAL_Y;
  logic [31:0] reg_cx = RST_CENTER_X;
  logic [31:0] reg_cy = RST_CENTER_Y;

  point_t pending_points[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     err_count = 0;
  int     cycle_count = 0;

  disparity_pixel_to_point u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // (coord<<16 - center) * z / focal, rounded half away from zero, saturated
  function automatic logic [31:0] scaled_offset(logic [31:0] z, logic [10:0] coord,
                                                logic [31:0] center, logic [31:0] focal);
    logic [95:0] pos, ctr, mag, f, prod, q;
    logic        neg;
    pos  = {69'd0, coord, 16'd0};
    ctr  = {64'd0, center};
    f    = (focal == 0) ? 96'd1 : {64'd0, focal};
    neg  = pos < ctr;
    mag  = neg ? ctr - pos : pos - ctr;
    prod = {64'd0, z} * mag;
    q    = (prod + f / 2) / f;
    if (neg) begin
      if (q > 96'h8000_0000) q = 96'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 96'h7FFF_FFFF) q = 96'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Back-project one pixel with the current register shadow
  function automatic point_t predict_point(logic [10:0] col, logic [10:0] row,
                                           logic [7:0] b0, logic [7:0] b1);
    logic [15:0] word;
    logic [10:0] disp;
    longint      den;
    logic [63:0] d, zq;
    logic [31:0] z;
    point_t      p;
    word = reg_be ? {b0, b1} : {b1, b0};
    disp = word[10:0];
    den  = longint'($signed(reg_a)) + longint'($signed(reg_b)) * longint'(disp);
    if (den <= 0) begin
      p.x = '0; p.y = '0; p.z = '0; p.inv = 1'b1;
      return p;
    end
    d  = den;
    zq = ((64'd1 << Z_ONE_BIT) + d / 2) / d;
    z  = (zq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : zq[31:0];
    p.x   = scaled_offset(z, col, reg_cx, reg_fx);
    p.y   = scaled_offset(z, row, reg_cy, reg_fy);
    p.z   = z;
    p.inv = 1'b0;
    return p;
  endfunction

  // Output side: random backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Output side: compare each transaction with the oldest prediction
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h z=%h inv=%b", $time,
                 point_x_o, point_y_o, point_z_o, invalid_o);
        err_count++;
      end else begin
        e = pending_points.pop_front();
        if (point_x_o !== e.x) begin
          $display("%0t: point_x expected %h actual %h", $time, e.x, point_x_o);
          err_count++;
        end
        if (point_y_o !== e.y) begin
          $display("%0t: point_y expected %h actual %h", $time, e.y, point_y_o);
          err_count++;
        end
        if (point_z_o !== e.z) begin
          $display("%0t: point_z expected %h actual %h", $time, e.z, point_z_o);
          err_count++;
        end
        if (invalid_o !== e.inv) begin
          $display("%0t: invalid expected %b actual %b", $time, e.inv, invalid_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYC_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Send one pixel; valid stays high afterwards unless the next call idles
  task automatic send_pixel(logic [10:0] col, logic [10:0] row, logic [7:0] b0, logic [7:0] b1);
    point_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    p = predict_point(col, row, b0, b1);
    in_valid_i    <= 1'b1;
    pixel_col_i   <= col;
    pixel_row_i   <= row;
    first_byte_i  <= b0;
    second_byte_i <= b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_points.push_back(p);
  endtask

  task automatic send_random_pixel();
    send_pixel(11'($urandom_range(2047)), 11'($urandom_range(2047)),
               8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Drop valid and let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // Register write; caller ends a group with end_writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_BIG_ENDIAN: reg_be = data[0];
      REG_OFFSET_A:   reg_a  = data;
      REG_SCALE_B:    reg_b  = data;
      REG_FOCAL_X:    reg_fx = data;
      REG_FOCAL_Y:    reg_fy = data;
      REG_CENTER_X:   reg_cx = data;
      REG_CENTER_Y:   reg_cy = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reset values: near, far and out-of-range disparities
  task automatic test_reset_defaults();
    send_pixel(11'd0, 11'd0, 8'h00, 8'h00);
    send_pixel(11'd2047, 11'd2047, 8'hFF, 8'hFF);
    send_pixel(11'd2047, 11'd0, 8'h00, 8'h04);
    send_pixel(11'd0, 11'd2047, 8'h3C, 8'h04);
    send_pixel(11'd320, 11'd240, 8'h3B, 8'h04);
    send_pixel(11'd1024, 11'd5, 8'hFF, 8'h00);
    wait_idle();
  endtask

  // Big-endian byte order
  task automatic test_byte_order();
    write_reg(REG_BIG_ENDIAN, 32'hFFFF_FFFF);
    end_writes();
    send_pixel(11'd100, 11'd200, 8'h04, 8'h00);
    send_pixel(11'd700, 11'd30, 8'hFF, 8'h00);
    send_pixel(11'd1, 11'd1, 8'hF8, 8'h3C);
    wait_idle();
  endtask

  // Zero and negative denominators, zero focal, saturation, unused index
  task automatic test_special_cases();
    write_reg(REG_OFFSET_A, 32'd0);
    write_reg(REG_SCALE_B, 32'd0);
    end_writes();
    send_pixel(11'd5, 11'd5, 8'h12, 8'h34);
    wait_idle();
    write_reg(REG_OFFSET_A, 32'h8000_0000);
    write_reg(REG_SCALE_B, 32'h7FFF_FFFF);
    end_writes();
    send_pixel(11'd5, 11'd5, 8'h00, 8'h00);
    send_pixel(11'd5, 11'd5, 8'h07, 8'hFF);
    wait_idle();
    write_reg(REG_OFFSET_A, 32'd1);
    write_reg(REG_FOCAL_X, 32'd0);
    write_reg(REG_FOCAL_Y, 32'd0);
    write_reg(REG_CENTER_X, 32'hFFFF_FFFF);
    write_reg(REG_CENTER_Y, 32'd0);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    end_writes();
    send_pixel(11'd0, 11'd2047, 8'h00, 8'h00);
    send_pixel(11'd2047, 11'd0, 8'h00, 8'h00);
    wait_idle();
    write_reg(REG_SCALE_B, 32'h8000_0000);
    write_reg(REG_OFFSET_A, 32'h7FFF_FFFF);
    write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
    write_reg(REG_FOCAL_Y, 32'd1);
    end_writes();
    send_pixel(11'd2047, 11'd3, 8'h00, 8'h00);
    send_pixel(11'd2047, 11'd3, 8'h01, 8'h00);
    wait_idle();
  endtask

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return RST_OFFSET_A + $urandom_range(8000000) - 4000000;
    endcase
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return 32'd0;
      default: return 32'd0 - $urandom_range(60000, 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_focal();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom();
      default: return $urandom_range(700, 300) << 16 | $urandom_range(65535);
    endcase
  endfunction

  function automatic logic [31:0] pick_center();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(2047) << 16 | $urandom_range(65535);
    endcase
  endfunction

  // One random register setting, then a stream of random pixels
  task automatic test_random_phase(int n_items);
    write_reg(REG_BIG_ENDIAN, $urandom());
    write_reg(REG_OFFSET_A, pick_offset());
    write_reg(REG_SCALE_B, pick_scale());
    write_reg(REG_FOCAL_X, pick_focal());
    write_reg(REG_FOCAL_Y, pick_focal());
    write_reg(REG_CENTER_X, pick_center());
    write_reg(REG_CENTER_Y, pick_center());
    end_writes();
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        in_valid_i <= 1'b0;
        wait (pending_points.size() == 0);
        @(posedge clk_i);
      end
      send_random_pixel();
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 35;
    recv_idle_pct = 81;
    test_reset_defaults();
    test_byte_order();
    test_special_cases();
    for (int ph = 0; ph < 2; ph++) test_random_phase(300);
    send_idle_pct = 81;
    recv_idle_pct = 35;
    for (int ph = 0; ph < 2; ph++) test_random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int ph = 0; ph < 2; ph++) test_random_phase(300);
    wait (pending_points.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
